### hdl/lap_pkg.sv
`default_nettype none
package lap_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DELAY_W    = 40;
  localparam int MAX_STAGES = 8;
  localparam int STAGE_IW   = $clog2(MAX_STAGES);
  localparam int NUM_W      = $clog2(MAX_STAGES + 1);
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int FRAC_W     = 16;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 48;
  localparam int SPLIT      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic [15:0] RST_WET_GAIN    = 16'd32767;
  localparam logic [22:0] RST_POLE_FREQ   = 23'd16530;
  localparam logic [15:0] RST_POLE_RADIUS = 16'd20716;
  localparam logic [3:0]  RST_STAGE_COUNT = 4'd1;
  localparam logic [19:0] RST_LFO_STEP    = 20'd8948;
  localparam logic [22:0] RST_LFO_AMOUNT  = 23'd436907;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WET_GAIN    = 3'd0,
    CFG_POLE_FREQ   = 3'd1,
    CFG_POLE_RADIUS = 3'd2,
    CFG_STAGE_COUNT = 3'd3,
    CFG_LFO_STEP    = 3'd4,
    CFG_LFO_AMOUNT  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] wet_gain;
    logic [22:0] pole_frequency;
    logic [15:0] pole_radius;
    logic [3:0]  stage_count;
    logic [19:0] lfo_step;
    logic [22:0] lfo_amount;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD,
    OP_SIN_A, OP_SIN_B, OP_SIN_C, OP_SIN_D,
    OP_M_MUL, OP_M_F,
    OP_A_MUL, OP_B_MUL, OP_B_DONE,
    OP_K0, OP_K1, OP_K2, OP_K3, OP_K4, OP_K5, OP_K6, OP_K7,
    OP_X0, OP_X1, OP_X2,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cos_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic no_stage;
    logic last_stage;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_L_SA, S_L_SB, S_L_SC, S_L_SD,
    S_M_MUL, S_M_F,
    S_C_SA, S_C_SB, S_C_SC, S_C_SD,
    S_A_MUL, S_B_MUL, S_B_DONE,
    S_K0, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_K7,
    S_X0, S_X1, S_X2,
    S_PUSH
  } ctrl_state_t;

  typedef logic signed [31:0] sine_tab_t [SINE_DEPTH];

  // quarter-wave Taylor series, folded out to a full cycle
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    longint      p;
    longint      r;
    longint      arg;
    longint      x2;
    longint      term;
    longint      sum;
    logic [1:0]  quad;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      p    = longint'(k) <<< (32 - SINE_AW);
      quad = 2'(p >>> 30);
      r    = p & (ONE_Q30 - 1);
      if (quad[0]) r = ONE_Q30 - r;
      arg  = (r * HALF_PI_Q30) >>> 30;
      x2   = (arg * arg) >>> 30;
      term = arg;
      sum  = arg;
      term = -(((term * x2) >>> 30) / 64'sd6);
      sum  = sum + term;
      term = -(((term * x2) >>> 30) / 64'sd20);
      sum  = sum + term;
      term = -(((term * x2) >>> 30) / 64'sd42);
      sum  = sum + term;
      term = -(((term * x2) >>> 30) / 64'sd72);
      sum  = sum + term;
      term = -(((term * x2) >>> 30) / 64'sd110);
      sum  = sum + term;
      term = -(((term * x2) >>> 30) / 64'sd156);
      sum  = sum + term;
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      tab[k] = quad[1] ? 32'(-sum) : 32'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine_tab();

endpackage
`default_nettype wire

### hdl/lfo_allpass_phaser_unit.sv
// One beat is processed at a time: a new input beat is taken only once the last one has been
// pushed to the output register. The single shared multiplier serves the LFO sine, the
//   cosine, the coefficients, every section and the wet/dry mix.
// Reset (rst_n low, synchronous): LFO phase and all section delays go to zero,
//   configuration registers take their default values, both channels go empty.
`default_nettype none
module lfo_allpass_phaser_unit import lap_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // sample input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [SAMPLE_W-1:0]   in_sample_in,
  input  wire logic                         in_block_end,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]        out_sample_out,
  output logic                              out_block_end_out,
  // register write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Register file: always ready, ignores indexes past the last register.
  lap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: one beat at a time. Steps the LFO sine lookup, the cosine
  // lookup for the pole angle, the two coefficient products, eight steps per
  // section and the wet/dry mix, then hands the result to the output register.
  lap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: sine ROM with registered read, one shared multiplier with a
  // product register, section delay lines and the output register. The
  // output register holds a finished beat while the next one is taken in.
  lap_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_sample  (in_sample_in),
    .in_be      (in_block_end),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample_out),
    .out_be     (out_block_end_out)
  );

  // Only one beat in flight: taking a beat closes the input at once.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second input beat taken while one is in flight");

  // A result appears only through the push step of the sequencer.
  a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == OP_PUSH))
    else $error("output valid rose without a push");

  // Never overwrite a result that is still held off by the receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PUSH) |-> !(out_valid && out_stall))
    else $error("push onto a stalled output register");

endmodule
`default_nettype wire

### hdl/lap_cfg.sv
`default_nettype none
module lap_cfg import lap_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wet_gain       <= RST_WET_GAIN;
      cfg_r.pole_frequency <= RST_POLE_FREQ;
      cfg_r.pole_radius    <= RST_POLE_RADIUS;
      cfg_r.stage_count    <= RST_STAGE_COUNT;
      cfg_r.lfo_step       <= RST_LFO_STEP;
      cfg_r.lfo_amount     <= RST_LFO_AMOUNT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WET_GAIN:    cfg_r.wet_gain       <= cfg_data[15:0];
        CFG_POLE_FREQ:   cfg_r.pole_frequency <= cfg_data[22:0];
        CFG_POLE_RADIUS: cfg_r.pole_radius    <= cfg_data[15:0];
        CFG_STAGE_COUNT: cfg_r.stage_count    <= cfg_data[3:0];
        CFG_LFO_STEP:    cfg_r.lfo_step       <= cfg_data[19:0];
        CFG_LFO_AMOUNT:  cfg_r.lfo_amount     <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/lap_dp.sv
`default_nettype none
module lap_dp import lap_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dp_cmd_t                    cmd,
  input  wire cfg_t                       cfg,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_be,
  output dp_stat_t                        stat,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  output logic                            out_be
);

  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
    logic top_one;
    logic top_zero;
    top_one  = &v[ACC_W-1:DELAY_W-1];
    top_zero = ~|v[ACC_W-1:DELAY_W-1];
    if (top_one || top_zero) return v[DELAY_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(DELAY_W-1){1'b0}}} : {1'b0, {(DELAY_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic top_one;
    logic top_zero;
    top_one  = &v[ACC_W-1:SAMPLE_W-1];
    top_zero = ~|v[ACC_W-1:SAMPLE_W-1];
    if (top_one || top_zero) return v[SAMPLE_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  function automatic logic signed [MUL_W-1:0] lo_part(input logic signed [DELAY_W-1:0] v);
    return $signed({{(MUL_W-SPLIT){1'b0}}, v[SPLIT-1:0]});
  endfunction

  function automatic logic signed [MUL_W-1:0] hi_part(input logic signed [DELAY_W-1:0] v);
    return MUL_W'(v >>> SPLIT);
  endfunction

  logic signed [SAMPLE_W-1:0] x_r;
  logic                       be_r;
  logic [31:0]                ph_r;
  logic [31:0]                cph_r;
  logic signed [31:0]         rom_q_r;
  logic signed [31:0]         s0_r;
  logic signed [31:0]         sin_r;
  logic signed [31:0]         c_r;
  logic signed [32:0]         a_r;
  logic signed [31:0]         b_r;
  logic signed [PROD_W-1:0]   p_r;
  logic signed [PROD_W-1:0]   t_r;
  logic signed [ACC_W-1:0]    q1_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [DELAY_W-1:0]  w_r;
  logic signed [DELAY_W-1:0]  y_r;
  logic signed [DELAY_W-1:0]  fd_r [MAX_STAGES];
  logic signed [DELAY_W-1:0]  sd_r [MAX_STAGES];
  logic [STAGE_IW-1:0]        k_r;
  logic signed [SAMPLE_W-1:0] mix_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_be_r;
  logic                       out_valid_r;

  logic [31:0]                sph;
  logic [SINE_AW-1:0]         sidx;
  logic [FRAC_W-1:0]          frac;
  logic [SINE_AW-1:0]         rom_addr;
  logic signed [DELAY_W-1:0]  w1;
  logic signed [DELAY_W-1:0]  w2;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]    q;
  logic signed [31:0]         s_new;
  logic signed [32:0]         m_sum;
  logic [30:0]                m;
  logic [24:0]                f;
  logic signed [PROD_W-1:0]   mix_sum;
  logic [NUM_W-1:0]           n_eff;

  assign sph      = cmd.cos_sel ? cph_r : ph_r;
  assign sidx     = sph[31 -: SINE_AW];
  assign frac     = sph[31-SINE_AW -: FRAC_W];
  assign rom_addr = (cmd.op == OP_SIN_B) ? SINE_AW'(sidx + 1'b1) : sidx;
  assign w1       = fd_r[k_r];
  assign w2       = sd_r[k_r];
  assign q        = ACC_W'((p_r + t_r) >>> SPLIT);
  assign s_new    = s0_r + 32'(p_r >>> 16);
  assign m_sum    = 33'sd1073741824 + {sin_r[31], sin_r};
  assign m        = m_sum[31:1];
  assign f        = 25'(cfg.pole_frequency) + 25'(p_r[53:30]);
  assign mix_sum  = (p_r <<< SPLIT) + t_r + (PROD_W'(x_r) <<< SPLIT);
  assign n_eff    = (cfg.stage_count > MAX_STAGES) ? NUM_W'(MAX_STAGES)
                                                   : NUM_W'(cfg.stage_count);

  assign stat.no_stage   = (cfg.stage_count == 4'd0);
  assign stat.last_stage = ((NUM_W'(k_r) + NUM_W'(1)) == n_eff);
  assign stat.out_busy   = out_valid_r & out_stall;

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_be     = out_be_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SIN_C: begin
        mul_a = MUL_W'($signed({rom_q_r[31], rom_q_r} - {s0_r[31], s0_r}));
        mul_b = $signed({{(MUL_W-FRAC_W){1'b0}}, frac});
      end
      OP_M_MUL: begin
        mul_a = $signed(MUL_W'(cfg.lfo_amount));
        mul_b = $signed(MUL_W'(m));
      end
      OP_A_MUL: begin
        mul_a = $signed(MUL_W'(cfg.pole_radius));
        mul_b = MUL_W'(c_r);
      end
      OP_B_MUL: begin
        mul_a = $signed(MUL_W'(cfg.pole_radius));
        mul_b = $signed(MUL_W'(cfg.pole_radius));
      end
      OP_K0: begin
        mul_a = lo_part(w1);
        mul_b = MUL_W'(a_r);
      end
      OP_K1: begin
        mul_a = hi_part(w1);
        mul_b = MUL_W'(a_r);
      end
      OP_K2: begin
        mul_a = lo_part(w2);
        mul_b = MUL_W'(b_r);
      end
      OP_K3: begin
        mul_a = hi_part(w2);
        mul_b = MUL_W'(b_r);
      end
      OP_K5: begin
        mul_a = lo_part(w_r);
        mul_b = MUL_W'(b_r);
      end
      OP_K6: begin
        mul_a = hi_part(w_r);
        mul_b = MUL_W'(b_r);
      end
      OP_X0: begin
        mul_a = lo_part(y_r);
        mul_b = MUL_W'($signed(cfg.wet_gain));
      end
      OP_X1: begin
        mul_a = hi_part(y_r);
        mul_b = MUL_W'($signed(cfg.wet_gain));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r     <= PROD_W'(mul_a) * PROD_W'(mul_b);
    rom_q_r <= SINE_ROM[rom_addr];
  end

  // state with a defined reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        fd_r[i] <= '0;
        sd_r[i] <= '0;
      end
    end else begin
      if (cmd.op == OP_B_DONE) k_r <= '0;
      if (cmd.op == OP_K7) begin
        fd_r[k_r] <= w_r;
        sd_r[k_r] <= w1;
        k_r       <= k_r + 1'b1;
      end
      if (cmd.op == OP_X2) ph_r <= ph_r + 32'(cfg.lfo_step);
      if (cmd.op == OP_PUSH) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        x_r  <= in_sample;
        be_r <= in_be;
        y_r  <= DELAY_W'(in_sample);
      end
      OP_SIN_B: s0_r <= rom_q_r;
      OP_SIN_D: begin
        if (cmd.cos_sel) c_r <= s_new;
        else sin_r <= s_new;
      end
      OP_M_F:    cph_r <= {f[23:0], 8'h00} + 32'h4000_0000;
      OP_B_MUL:  a_r   <= {p_r[47:16], 1'b0};
      OP_B_DONE: b_r   <= $signed(p_r[33:2]);
      OP_K1, OP_K3, OP_K6: t_r <= p_r >>> SPLIT;
      OP_K2: begin
        q1_r  <= q;
        acc_r <= ACC_W'(y_r) + q;
      end
      OP_K4: w_r <= sat_delay(acc_r - q);
      OP_K7: y_r <= sat_delay(q - q1_r + ACC_W'(w2));
      OP_X1: t_r <= p_r;
      OP_X2: mix_r <= sat_sample(ACC_W'(mix_sum >>> 16));
      OP_PUSH: begin
        out_sample_r <= mix_r;
        out_be_r     <= be_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/lap_ctrl.sv
`default_nettype none
module lap_ctrl import lap_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_L_SA;
      S_L_SA:   state_nxt = S_L_SB;
      S_L_SB:   state_nxt = S_L_SC;
      S_L_SC:   state_nxt = S_L_SD;
      S_L_SD:   state_nxt = S_M_MUL;
      S_M_MUL:  state_nxt = S_M_F;
      S_M_F:    state_nxt = S_C_SA;
      S_C_SA:   state_nxt = S_C_SB;
      S_C_SB:   state_nxt = S_C_SC;
      S_C_SC:   state_nxt = S_C_SD;
      S_C_SD:   state_nxt = S_A_MUL;
      S_A_MUL:  state_nxt = S_B_MUL;
      S_B_MUL:  state_nxt = S_B_DONE;
      S_B_DONE: state_nxt = stat.no_stage ? S_X0 : S_K0;
      S_K0:     state_nxt = S_K1;
      S_K1:     state_nxt = S_K2;
      S_K2:     state_nxt = S_K3;
      S_K3:     state_nxt = S_K4;
      S_K4:     state_nxt = S_K5;
      S_K5:     state_nxt = S_K6;
      S_K6:     state_nxt = S_K7;
      S_K7:     state_nxt = stat.last_stage ? S_X0 : S_K0;
      S_X0:     state_nxt = S_X1;
      S_X1:     state_nxt = S_X2;
      S_X2:     state_nxt = S_PUSH;
      S_PUSH:   if (!stat.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.op      = OP_NOP;
    cmd.cos_sel = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.op   = in_valid ? OP_LOAD : OP_NOP;
      end
      S_L_SA:   cmd.op = OP_SIN_A;
      S_L_SB:   cmd.op = OP_SIN_B;
      S_L_SC:   cmd.op = OP_SIN_C;
      S_L_SD:   cmd.op = OP_SIN_D;
      S_M_MUL:  cmd.op = OP_M_MUL;
      S_M_F:    cmd.op = OP_M_F;
      S_C_SA: begin
        cmd.op = OP_SIN_A;
        cmd.cos_sel = 1'b1;
      end
      S_C_SB: begin
        cmd.op = OP_SIN_B;
        cmd.cos_sel = 1'b1;
      end
      S_C_SC: begin
        cmd.op = OP_SIN_C;
        cmd.cos_sel = 1'b1;
      end
      S_C_SD: begin
        cmd.op = OP_SIN_D;
        cmd.cos_sel = 1'b1;
      end
      S_A_MUL:  cmd.op = OP_A_MUL;
      S_B_MUL:  cmd.op = OP_B_MUL;
      S_B_DONE: cmd.op = OP_B_DONE;
      S_K0:     cmd.op = OP_K0;
      S_K1:     cmd.op = OP_K1;
      S_K2:     cmd.op = OP_K2;
      S_K3:     cmd.op = OP_K3;
      S_K4:     cmd.op = OP_K4;
      S_K5:     cmd.op = OP_K5;
      S_K6:     cmd.op = OP_K6;
      S_K7:     cmd.op = OP_K7;
      S_X0:     cmd.op = OP_X0;
      S_X1:     cmd.op = OP_X1;
      S_X2:     cmd.op = OP_X2;
      S_PUSH:   cmd.op = stat.out_busy ? OP_NOP : OP_PUSH;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### tb/lfo_allpass_phaser_checker.sv
`default_nettype none
module lfo_allpass_phaser_checker import lap_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                       in_block_end,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic signed [SAMPLE_W-1:0] out_sample_out,
  input  wire logic                       out_block_end_out,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  output int                              mismatches,
  output int                              awaiting
);

  typedef struct {
    logic signed [SAMPLE_W-1:0] mixed;
    logic                       block_end;
  } mix_beat_t;

  longint      sine_lut [SINE_DEPTH];
  longint      delay_a [MAX_STAGES];
  longint      delay_b [MAX_STAGES];
  logic [31:0] phase_acc;
  logic [15:0] wet_q;
  logic [22:0] freq_q;
  logic [15:0] radius_q;
  logic [3:0]  stages_q;
  logic [19:0] step_q;
  logic [22:0] depth_q;
  mix_beat_t   mix_q [$];

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // floor(w * c / 2^30) split in two halves to stay within 64 bits
  function automatic longint scale_q30(longint w, longint c);
    longint wh;
    longint wl;
    wh = w >>> 15;
    wl = w - wh * 32768;
    return (wh * c + ((wl * c) >>> 15)) >>> 15;
  endfunction

  function automatic longint lut_sine(logic [31:0] ph);
    int     i;
    int     j;
    longint fr;
    longint s0;
    longint s1;
    i  = ph[31:22];
    j  = (i + 1) % SINE_DEPTH;
    fr = longint'(ph[21:6]);
    s0 = sine_lut[i];
    s1 = sine_lut[j];
    return s0 + (((s1 - s0) * fr) >>> 16);
  endfunction

  initial begin
    longint p, r, x, x2, term, acc;
    int     quad;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      p    = longint'(k) * (longint'(1) <<< 32) / SINE_DEPTH;
      quad = int'((p >>> 30) & 3);
      r    = p & (ONE_Q30 - 1);
      if (quad % 2 == 1) r = ONE_Q30 - r;
      x    = (r * HALF_PI_Q30) >>> 30;
      x2   = (x * x) >>> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 6; n++) begin
        term = -(((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1)));
        acc  = acc + term;
      end
      if (acc < 0) acc = 0;
      if (acc > ONE_Q30) acc = ONE_Q30;
      sine_lut[k] = (quad >= 2) ? -acc : acc;
    end
  end

  task automatic predict_mix(input logic signed [SAMPLE_W-1:0] dry, input logic be);
    longint      x, wet, s, m, f, c, ra, ca, cb, y, w, w1, w2;
    logic [31:0] cph;
    int          n;
    mix_beat_t   e;
    x   = longint'(dry);
    wet = longint'($signed(wet_q));
    s   = lut_sine(phase_acc);
    m   = (ONE_Q30 + s) >>> 1;
    f   = longint'(freq_q) + ((longint'(depth_q) * m) >>> 30);
    cph = 32'((f <<< 8) + ONE_Q30);
    c   = lut_sine(cph);
    ra  = longint'(radius_q);
    ca  = 2 * ((ra * c) >>> 16);
    cb  = (ra * ra) >>> 2;
    n   = (stages_q > MAX_STAGES) ? MAX_STAGES : int'(stages_q);
    y   = x;
    for (int k = 0; k < n; k++) begin
      w1 = delay_a[k];
      w2 = delay_b[k];
      w  = sat_to(y + scale_q30(w1, ca) - scale_q30(w2, cb), DELAY_W);
      y  = sat_to(scale_q30(w, cb) - scale_q30(w1, ca) + w2, DELAY_W);
      delay_b[k] = w1;
      delay_a[k] = w;
    end
    e.mixed     = SAMPLE_W'(sat_to((y * wet + x * 32768) >>> 16, SAMPLE_W));
    e.block_end = be;
    mix_q.push_back(e);
    phase_acc = phase_acc + 32'(step_q);
  endtask

  always @(posedge clk) begin
    mix_beat_t e;
    if (!rst_n) begin
      for (int k = 0; k < MAX_STAGES; k++) begin
        delay_a[k] = 0;
        delay_b[k] = 0;
      end
      phase_acc = '0;
      wet_q     = RST_WET_GAIN;
      freq_q    = RST_POLE_FREQ;
      radius_q  = RST_POLE_RADIUS;
      stages_q  = RST_STAGE_COUNT;
      step_q    = RST_LFO_STEP;
      depth_q   = RST_LFO_AMOUNT;
      mix_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WET_GAIN:    wet_q    = cfg_data[15:0];
          CFG_POLE_FREQ:   freq_q   = cfg_data[22:0];
          CFG_POLE_RADIUS: radius_q = cfg_data[15:0];
          CFG_STAGE_COUNT: stages_q = cfg_data[3:0];
          CFG_LFO_STEP:    step_q   = cfg_data[19:0];
          CFG_LFO_AMOUNT:  depth_q  = cfg_data[22:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_mix(in_sample_in, in_block_end);
      if (out_valid && !out_stall) begin
        if (mix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: sample %0d end %0b", out_sample_out, out_block_end_out);
        end else begin
          e = mix_q.pop_front();
          if (out_sample_out !== e.mixed || out_block_end_out !== e.block_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sample exp %0d got %0d, end exp %0b got %0b",
                       e.mixed, out_sample_out, e.block_end, out_block_end_out);
          end
        end
      end
    end
    awaiting = mix_q.size();
  end

endmodule
`default_nettype wire

### tb/lfo_allpass_phaser_unit_tb.sv
`default_nettype none
module lfo_allpass_phaser_unit_tb;
  import lap_pkg::*;

  // indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 200;   // allow well over the worst latency
  localparam int CYCLE_LIMIT  = 2000000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_block_end;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_block_end_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  int                         mismatches;
  int                         awaiting;
  int                         cycle_no;
  bit                         calm;    // set for the stretch with no idling on either side

  lfo_allpass_phaser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .in_block_end(in_block_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .out_block_end_out(out_block_end_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lfo_allpass_phaser_checker mix_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_in(in_sample_in), .in_block_end(in_block_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sample_out(out_sample_out), .out_block_end_out(out_block_end_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: a hung handshake lands here.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("[lfo_allpass_phaser_unit] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: stall at random with a chance of 11 in a hundred, never in the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= !calm && ($urandom_range(99) < 11);
  end

  // Drive one sample beat; hold payload until the block takes it.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic be);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    in_block_end <= be;
    do @(posedge clk); while (in_stall);
  endtask

  // Let the pipeline drain, then write one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2, 3:    return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Fresh random setting with the extremes weighted in.
  task automatic shuffle_settings();
    logic [CFG_DATA_W-1:0] v;
    v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 23'h7FFF : 23'h8000) : 23'($urandom);
    write_reg(CFG_WET_GAIN, v);
    v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 23'h7FFFFF : 23'd0) : 23'($urandom);
    write_reg(CFG_POLE_FREQ, v);
    v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 23'd65503 : 23'd655)
                                 : 23'($urandom_range(65535));
    write_reg(CFG_POLE_RADIUS, v);
    v = ($urandom_range(7) == 0) ? 23'($urandom_range(15)) : 23'($urandom_range(8));
    write_reg(CFG_STAGE_COUNT, v);
    v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 23'hFFFFF : 23'd0) : 23'($urandom);
    write_reg(CFG_LFO_STEP, v);
    v = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 23'h7FFFFF : 23'd0) : 23'($urandom);
    write_reg(CFG_LFO_AMOUNT, v);
  endtask

  initial begin
    int sent;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_block_end = 1'b0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_WET_GAIN;
    cfg_data     = '0;
    cycle_no     = 0;
    calm         = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: defaults first, then the field extremes.
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);

    // No sections: dry path with gain only; minimum wet gain.
    write_reg(CFG_STAGE_COUNT, 23'd0);
    write_reg(CFG_WET_GAIN, 23'h8000);
    send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);

    // Stage count over the maximum clamps; radius at its top edge.
    write_reg(CFG_WET_GAIN, 23'h7FFF);
    write_reg(CFG_STAGE_COUNT, 23'd15);
    write_reg(CFG_POLE_RADIUS, 23'hFFFF);
    write_reg(CFG_POLE_FREQ, 23'h7FFFFF);   // just under one half: wraps in the cosine
    write_reg(CFG_LFO_AMOUNT, 23'h7FFFFF);
    write_reg(CFG_LFO_STEP, 23'hFFFFF);
    repeat (6) send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
    repeat (3) send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);

    // Dropped writes to unmapped indexes; radius zero, frozen LFO, eight sections.
    write_reg(CFG_SPARE_LO, 23'h7FFFFF);
    write_reg(CFG_SPARE_HI, 23'h000001);
    write_reg(CFG_POLE_RADIUS, 23'd0);
    write_reg(CFG_LFO_STEP, 23'd0);
    write_reg(CFG_POLE_FREQ, 23'd0);
    write_reg(CFG_LFO_AMOUNT, 23'd0);
    write_reg(CFG_STAGE_COUNT, 23'd8);
    send_sample(24'sd1000, 1'b0);
    send_sample(-24'sd1000, 1'b1);
    write_reg(CFG_POLE_RADIUS, 23'd65503);
    repeat (4) send_sample(pick_sample(), 1'b0);

    // Random phases of samples with a new setting between each.
    sent = 0;
    while (sent < 1150) begin
      shuffle_settings();
      repeat ($urandom_range(140, 60)) begin
        if (sent < 1150) begin
          calm = (sent >= 500 && sent < 700);
          send_sample(pick_sample(), ($urandom_range(15) == 0));
          sent++;
        end
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain and settle.
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaiting == 0)
      $display("[lfo_allpass_phaser_unit] OK");
    else
      $display("[lfo_allpass_phaser_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
